/* hdl/glsa_pkg.sv */
package glsa_pkg;

    localparam int SpeedW = 14;
    localparam int DistW  = 18;
    localparam int TimeW  = 16;
    localparam int NumW   = 22;
    localparam int DenW   = 17;
    localparam int ProdW  = 31;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_MSG     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [3:0] PHASE_RED     = 4'd3;
    localparam logic [3:0] PHASE_GREEN_A = 4'd5;
    localparam logic [3:0] PHASE_GREEN_B = 4'd6;
    localparam logic [3:0] PHASE_YELLOW  = 4'd7;

    localparam logic [2:0] COL_NONE   = 3'd0;
    localparam logic [2:0] COL_GREEN  = 3'd1;
    localparam logic [2:0] COL_LIME   = 3'd2;
    localparam logic [2:0] COL_YGREEN = 3'd3;
    localparam logic [2:0] COL_AMBER  = 3'd4;
    localparam logic [2:0] COL_ORANGE = 3'd5;

    localparam logic [2:0] REG_MIN_SPEED = 3'd0;
    localparam logic [2:0] REG_MIN_DIST  = 3'd1;
    localparam logic [2:0] REG_MAX_DIST  = 3'd2;
    localparam logic [2:0] REG_PASS_DIST = 3'd3;
    localparam logic [2:0] REG_BUFFER    = 3'd4;
    localparam logic [2:0] REG_RG_LEN    = 3'd5;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic decide;
        logic div_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } status_t;

endpackage

/* hdl/glsa_ctrl.sv */
module glsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  glsa_pkg::status_t stat,
    output glsa_pkg::cmd_t    cmd
);

    glsa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            glsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = glsa_pkg::ST_EVAL;
                end
            end
            glsa_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
                state_next = glsa_pkg::ST_MUL;
            end
            glsa_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = glsa_pkg::ST_DECIDE;
            end
            glsa_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next = glsa_pkg::ST_DIV;
                end else begin
                    state_next = glsa_pkg::ST_FINISH;
                end
            end
            glsa_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = glsa_pkg::ST_FINISH;
                end
            end
            glsa_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = glsa_pkg::ST_OUT;
            end
            glsa_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = glsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = glsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/glsa_datapath.sv */
module glsa_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  glsa_pkg::cmd_t               cmd,
    output glsa_pkg::status_t            stat,
    input  logic                         cfg_valid,
    input  logic [2:0]                   cfg_index,
    input  logic [17:0]                  cfg_data,
    input  logic [1:0]                   kind,
    input  logic                         light_found,
    input  logic [15:0]                  intersection_id,
    input  logic                         phase_known,
    input  logic [3:0]                   light_phase,
    input  logic                         timing_known,
    input  logic [glsa_pkg::TimeW-1:0]   time_to_change,
    input  logic                         stop_known,
    input  logic [glsa_pkg::DistW-1:0]   stop_distance,
    input  logic [glsa_pkg::SpeedW-1:0]  current_speed,
    input  logic [glsa_pkg::SpeedW-1:0]  allowed_speed,
    output logic                         engage,
    output logic                         release_res,
    output logic [glsa_pkg::SpeedW-1:0]  advised_speed,
    output logic [2:0]                   color_code,
    output logic                         engaged_now,
    output logic [15:0]                  disengage_count
);

    localparam int SW = glsa_pkg::SpeedW;
    localparam int NW = glsa_pkg::NumW;
    localparam int DW = glsa_pkg::DenW;
    localparam int PW = glsa_pkg::ProdW;

    logic [SW-1:0] min_speed_reg;
    logic [17:0]   min_dist_reg, max_dist_reg, pass_dist_reg;
    logic [9:0]    buffer_reg;
    logic [11:0]   rg_len_reg;

    logic          alive_reg, engaged_reg;
    logic [15:0]   passed_reg, count_reg;

    logic [1:0]    kind_reg;
    logic          found_reg, phk_reg, tk_reg, sk_reg;
    logic [15:0]   id_reg;
    logic [3:0]    phase_reg;
    logic [15:0]   ttc_reg;
    logic [17:0]   sd_reg;
    logic [SW-1:0] cur_reg, allow_reg;

    logic [NW-1:0] n_reg;
    logic [DW-1:0] dmin_reg, dmax_reg;
    logic [PW-1:0] p_allow_dmin_reg, p_min_dmax_reg, p_cur_dmin_reg, p_cur_dmax_reg;
    logic [PW-1:0] p_yel_reg;

    logic          eng_reg, rel_reg;
    logic [SW-1:0] adv_reg;
    logic [2:0]    col_reg;

    // Decision flags latched at the decide step.
    logic          div_min_reg, cap_dmax_reg, green_act_reg;

    logic [NW-1:0] rem_reg, quo_reg;
    logic [DW-1:0] div_den_reg;
    logic [4:0]    div_cnt_reg;
    logic          div_busy_reg;

    logic [17:0]   d_val;
    logic [15:0]   tc_val;
    logic          is_green, is_red;
    logic [16:0]   ge_val, gs_val;

    assign d_val    = sk_reg ? sd_reg : 18'd0;
    assign tc_val   = tk_reg ? ttc_reg : 16'd0;
    assign is_green = (phase_reg == glsa_pkg::PHASE_GREEN_A) ||
                      (phase_reg == glsa_pkg::PHASE_GREEN_B);
    assign is_red   = (phase_reg == glsa_pkg::PHASE_RED);
    assign gs_val   = is_green ? 17'd0 : {1'b0, tc_val};
    assign ge_val   = is_green ? {1'b0, tc_val} : ({1'b0, tc_val} + {5'd0, rg_len_reg});

    logic [NW:0]   rem_try;
    logic [NW-1:0] rem_shift;
    assign rem_shift = {rem_reg[NW-2:0], quo_reg[NW-1]};
    assign rem_try   = {1'b0, rem_shift} - {{(NW+1-DW){1'b0}}, div_den_reg};

    assign stat.div_done = div_busy_reg && (div_cnt_reg == 5'd0);

    logic fail_w, yel_ok;
    assign fail_w = ({9'd0, n_reg} > p_allow_dmin_reg) || (allow_reg < min_speed_reg) ||
                    (!is_green && ({9'd0, n_reg} < p_min_dmax_reg));
    assign yel_ok = {9'd0, n_reg} < p_yel_reg;

    logic        active;
    logic        passed_case, range_bad, light_phase_case;
    assign active = (kind_reg == glsa_pkg::KIND_TICK) && alive_reg && found_reg &&
                    (id_reg != passed_reg) && phk_reg;
    assign passed_case = sk_reg && (d_val <= pass_dist_reg);
    assign range_bad   = (d_val < min_dist_reg) || (d_val > max_dist_reg);
    assign light_phase_case = is_green || is_red;
    assign stat.need_div = active && !passed_case && !range_bad && light_phase_case &&
                           !fail_w && ((p_cur_dmin_reg < {9'd0, n_reg}) ||
                           ((cur_reg > allow_reg || (!is_green && p_cur_dmax_reg > {9'd0, n_reg}))
                           && !is_green && !(cur_reg > allow_reg && 1'b0)));

    logic [SW-1:0] tgt;
    logic [SW-1:0] diff;
    logic [NW-1:0] q_cap;
    assign q_cap = quo_reg;
    always_comb begin
        if (div_min_reg) begin
            tgt = quo_reg[SW-1:0];
        end else if (cap_dmax_reg) begin
            tgt = (q_cap < {{(NW-SW){1'b0}}, allow_reg}) ? q_cap[SW-1:0] : allow_reg;
        end else if (green_act_reg) begin
            tgt = allow_reg;
        end else begin
            tgt = cur_reg;
        end
        diff = (tgt > cur_reg) ? tgt - cur_reg : cur_reg - tgt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_speed_reg <= SW'(768);
            min_dist_reg  <= 18'd2560;
            max_dist_reg  <= 18'd102400;
            pass_dist_reg <= 18'd512;
            buffer_reg    <= 10'd20;
            rg_len_reg    <= 12'd200;
            alive_reg     <= 1'b0;
            engaged_reg   <= 1'b0;
            passed_reg    <= '0;
            count_reg     <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    glsa_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data[SW-1:0];
                    glsa_pkg::REG_MIN_DIST:  min_dist_reg  <= cfg_data;
                    glsa_pkg::REG_MAX_DIST:  max_dist_reg  <= cfg_data;
                    glsa_pkg::REG_PASS_DIST: pass_dist_reg <= cfg_data;
                    glsa_pkg::REG_BUFFER:    buffer_reg    <= cfg_data[9:0];
                    glsa_pkg::REG_RG_LEN:    rg_len_reg    <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'(NW);
            end else if (div_busy_reg) begin
                if (div_cnt_reg == 5'd0) begin
                    div_busy_reg <= 1'b0;
                end else begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
            end
            if (cmd.finish) begin
                if (div_min_reg || cap_dmax_reg || green_act_reg || eng_reg) begin
                    engaged_reg <= 1'b1;
                end
            end
            if (cmd.decide) begin
                case (kind_reg)
                    glsa_pkg::KIND_MSG: alive_reg <= 1'b1;
                    glsa_pkg::KIND_TIMEOUT: begin
                        alive_reg <= 1'b0;
                        if (engaged_reg && count_reg != 16'hFFFF) begin
                            count_reg <= count_reg + 16'd1;
                        end
                        engaged_reg <= 1'b0;
                    end
                    glsa_pkg::KIND_TICK: begin
                        if (alive_reg) begin
                            if (!found_reg) begin
                                engaged_reg <= 1'b0;
                                passed_reg  <= '0;
                            end else if (active) begin
                                if (passed_case) begin
                                    passed_reg <= id_reg;
                                    if (engaged_reg && count_reg != 16'hFFFF) begin
                                        count_reg <= count_reg + 16'd1;
                                    end
                                    engaged_reg <= 1'b0;
                                end else if (range_bad) begin
                                    engaged_reg <= 1'b0;
                                end else if (light_phase_case) begin
                                    if (fail_w) begin
                                        engaged_reg <= 1'b0;
                                    end
                                end else if (phase_reg == glsa_pkg::PHASE_YELLOW) begin
                                    if (!yel_ok) begin
                                        engaged_reg <= 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind;
            found_reg <= light_found;
            id_reg    <= intersection_id;
            phk_reg   <= phase_known;
            phase_reg <= light_phase;
            tk_reg    <= timing_known;
            ttc_reg   <= time_to_change;
            sk_reg    <= stop_known;
            sd_reg    <= stop_distance;
            cur_reg   <= current_speed;
            allow_reg <= allowed_speed;
        end
        if (cmd.eval) begin
            n_reg    <= NW'({d_val, 3'd0}) + NW'({d_val, 1'b0});
            dmin_reg <= (ge_val > {7'd0, buffer_reg}) ? ge_val - {7'd0, buffer_reg} : 17'd1;
            dmax_reg <= ((gs_val + {7'd0, buffer_reg}) == 17'd0) ? 17'd1 :
                        gs_val + {7'd0, buffer_reg};
        end
        if (cmd.mul) begin
            p_allow_dmin_reg <= PW'(allow_reg * dmin_reg);
            p_min_dmax_reg   <= PW'(min_speed_reg * dmax_reg);
            p_cur_dmin_reg   <= PW'(cur_reg * dmin_reg);
            p_cur_dmax_reg   <= PW'(cur_reg * dmax_reg);
            p_yel_reg        <= PW'(tc_val * ((cur_reg < SW'(256)) ? SW'(256) : cur_reg));
        end
        if (cmd.decide) begin
            eng_reg       <= 1'b0;
            rel_reg       <= 1'b0;
            col_reg       <= glsa_pkg::COL_NONE;
            adv_reg       <= '0;
            div_min_reg   <= 1'b0;
            cap_dmax_reg  <= 1'b0;
            green_act_reg <= 1'b0;
            case (kind_reg)
                glsa_pkg::KIND_TIMEOUT: begin
                    rel_reg <= engaged_reg;
                    col_reg <= glsa_pkg::COL_ORANGE;
                end
                glsa_pkg::KIND_TICK: begin
                    if (alive_reg && !found_reg) begin
                        rel_reg <= engaged_reg;
                    end else if (active) begin
                        if (passed_case) begin
                            rel_reg <= engaged_reg;
                            col_reg <= glsa_pkg::COL_ORANGE;
                        end else if (range_bad) begin
                            rel_reg <= engaged_reg;
                        end else if (light_phase_case) begin
                            if (fail_w) begin
                                rel_reg <= engaged_reg;
                                col_reg <= glsa_pkg::COL_ORANGE;
                            end else if (p_cur_dmin_reg < {9'd0, n_reg}) begin
                                div_min_reg <= 1'b1;
                            end else if (cur_reg > allow_reg ||
                                         (!is_green && p_cur_dmax_reg > {9'd0, n_reg})) begin
                                if (is_green) begin
                                    green_act_reg <= 1'b1;
                                end else begin
                                    cap_dmax_reg <= 1'b1;
                                end
                            end else begin
                                eng_reg <= 1'b1;
                                adv_reg <= cur_reg;
                                col_reg <= glsa_pkg::COL_GREEN;
                            end
                        end else if (phase_reg == glsa_pkg::PHASE_YELLOW) begin
                            if (yel_ok) begin
                                eng_reg <= 1'b1;
                                adv_reg <= cur_reg;
                                col_reg <= glsa_pkg::COL_AMBER;
                            end else begin
                                rel_reg <= engaged_reg;
                                col_reg <= glsa_pkg::COL_ORANGE;
                            end
                        end else begin
                            eng_reg <= 1'b1;
                            adv_reg <= cur_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (cmd.div_start) begin
            quo_reg     <= n_reg;
            rem_reg     <= '0;
            div_den_reg <= (p_cur_dmin_reg < {9'd0, n_reg}) ? dmin_reg : dmax_reg;
        end else if (div_busy_reg && div_cnt_reg != 5'd0) begin
            if (!rem_try[NW]) begin
                rem_reg <= rem_try[NW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.finish && (div_min_reg || cap_dmax_reg || green_act_reg)) begin
            eng_reg <= 1'b1;
            adv_reg <= tgt;
            col_reg <= (diff < SW'(256)) ? glsa_pkg::COL_GREEN :
                       ((tgt > cur_reg) ? glsa_pkg::COL_LIME : glsa_pkg::COL_YGREEN);
        end
    end

    assign engage          = eng_reg;
    assign release_res     = rel_reg;
    assign advised_speed   = adv_reg;
    assign color_code      = col_reg;
    assign engaged_now     = engaged_reg;
    assign disengage_count = count_reg;

endmodule

/* hdl/green_light_speed_advisor_unit.sv */
// Speed advisory unit. One item (tick, message, or timeout) is handled at a time and yields
// exactly one result beat. An item goes through eval, multiply, decide and finish, plus a
// divide by the 22-step shift-subtract divider when a speed bound must be divided out.
// Configuration writes are always accepted and must only be issued while idle.
module green_light_speed_advisor_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [17:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic                         s_light_found,
    input  logic [15:0]                  s_intersection_id,
    input  logic                         s_phase_known,
    input  logic [3:0]                   s_light_phase,
    input  logic                         s_timing_known,
    input  logic [15:0]                  s_time_to_change,
    input  logic                         s_stop_known,
    input  logic [17:0]                  s_stop_distance,
    input  logic [13:0]                  s_current_speed,
    input  logic [13:0]                  s_allowed_speed,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_engage,
    output logic                         m_release_res,
    output logic [13:0]                  m_advised_speed,
    output logic [2:0]                   m_color_code,
    output logic                         m_engaged_now,
    output logic [15:0]                  m_disengage_count
);

    glsa_pkg::cmd_t    cmd;
    glsa_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    glsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    glsa_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (s_kind),
        .light_found     (s_light_found),
        .intersection_id (s_intersection_id),
        .phase_known     (s_phase_known),
        .light_phase     (s_light_phase),
        .timing_known    (s_timing_known),
        .time_to_change  (s_time_to_change),
        .stop_known      (s_stop_known),
        .stop_distance   (s_stop_distance),
        .current_speed   (s_current_speed),
        .allowed_speed   (s_allowed_speed),
        .engage          (m_engage),
        .release_res     (m_release_res),
        .advised_speed   (m_advised_speed),
        .color_code      (m_color_code),
        .engaged_now     (m_engaged_now),
        .disengage_count (m_disengage_count)
    );

endmodule

/* hdl/glsa_checker.sv */
module glsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_engage,
    input logic        m_release_res,
    input logic [13:0] m_advised_speed,
    input logic [2:0]  m_color_code,
    input logic        m_engaged_now,
    input logic [15:0] m_disengage_count
);

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("input taken while a result is pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_advised_speed) && $stable(m_color_code)
        && $stable(m_disengage_count))
        else $error("stalled result changed");

    a_eng_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_engage && m_release_res))
        else $error("engage and release together");

    a_adv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_engage |-> m_advised_speed == 14'd0)
        else $error("advised speed without engage");

    a_eng_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_engage |-> m_engaged_now)
        else $error("engage without engaged flag");

endmodule

bind green_light_speed_advisor_unit glsa_checker u_glsa_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_engage          (m_engage),
    .m_release_res     (m_release_res),
    .m_advised_speed   (m_advised_speed),
    .m_color_code      (m_color_code),
    .m_engaged_now     (m_engaged_now),
    .m_disengage_count (m_disengage_count)
);
